/* sv/four_channel_tracker_voice_mixer_top_assert.svh */
// assertion macros for the tracker voice mixer
`ifndef FOUR_CHANNEL_TRACKER_VOICE_MIXER_TOP_ASSERT_SVH
`define FOUR_CHANNEL_TRACKER_VOICE_MIXER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FTVM_ASSERT_IMM(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tracker mixer assertion failed");
`define FTVM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tracker mixer assertion failed");
`else
`define FTVM_ASSERT_IMM(label, clk, rst_n, ante, cons)
`define FTVM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* sv/ftvm_pkg.sv */
package ftvm_pkg;

	localparam int unsigned SAMPLE_MEMORY_DEPTH_DEF = 131072;
	localparam int unsigned VOICES_DEF = 4;
	localparam int unsigned PHASE_FRACTION_BITS_DEF = 16;

	localparam longint unsigned PAULA_CLOCK = 64'd14317456;
	localparam longint unsigned RATE_DIVISOR = 64'd176400;

	localparam logic [11:0] PERIOD_MIN = 12'd113;
	localparam logic [11:0] PERIOD_MAX = 12'd856;
	localparam logic [6:0] VOLUME_MAX = 7'd64;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_ROW = 2'd1;
	localparam logic [1:0] OP_TICK = 2'd2;
	localparam logic [1:0] OP_MIX = 2'd3;

	localparam logic [3:0] EFF_SLIDE_UP = 4'd1;
	localparam logic [3:0] EFF_SLIDE_DOWN = 4'd2;
	localparam logic [3:0] EFF_TONE_PORTA = 4'd3;
	localparam logic [3:0] EFF_PORTA_VOL = 4'd5;
	localparam logic [3:0] EFF_OFFSET = 4'd9;
	localparam logic [3:0] EFF_VOL_SLIDE = 4'd10;
	localparam logic [3:0] EFF_SET_VOL = 4'd12;

	typedef struct packed {
		logic [1:0] opcode;
		logic [1:0] channel;
		logic [16:0] address;
		logic signed [7:0] data_byte;
		logic [11:0] period;
		logic new_instrument;
		logic [16:0] sample_length;
		logic [16:0] loop_start;
		logic [16:0] loop_length;
		logic [6:0] instrument_volume;
		logic [3:0] effect;
		logic [7:0] argument;
	} in_item_t;

	typedef struct packed {
		logic signed [14:0] mixed_sample;
		logic [3:0] active_voices;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic mix_start;
		logic voice_eval;
		logic div_step;
		logic voice_done;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic voice_live;
		logic div_done;
		logic last_voice;
		logic out_free;
	} dp_status_t;

endpackage

/* sv/ftvm_chan_if.sv */
interface ftvm_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* sv/ftvm_ram.sv */
module ftvm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata_q
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

/* sv/ftvm_ctrl.sv */
module ftvm_ctrl
	import ftvm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] opcode,
	output logic in_ready,
	input dp_status_t st,
	output ctrl_cmd_t cmd
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_DIV = 5'b00100,
		S_ACC = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		in_ready = (state_q == S_IDLE);
		cmd.accept = in_valid && in_ready;
		cmd.mix_start = cmd.accept && (opcode == OP_MIX);
		cmd.voice_eval = (state_q == S_EVAL);
		cmd.div_step = (state_q == S_DIV);
		cmd.voice_done = (state_q == S_ACC);
		cmd.out_load = (state_q == S_OUT) && st.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.mix_start) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = st.voice_live ? S_DIV : S_ACC;
			end
			S_DIV: begin
				if (st.div_done) state_d = S_ACC;
			end
			S_ACC: begin
				state_d = st.last_voice ? S_OUT : S_EVAL;
			end
			S_OUT: begin
				if (st.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

/* sv/ftvm_dp.sv */
module ftvm_dp
	import ftvm_pkg::*;
#(
	parameter int unsigned SAMPLE_MEMORY_DEPTH = SAMPLE_MEMORY_DEPTH_DEF,
	parameter int unsigned VOICES = VOICES_DEF,
	parameter int unsigned PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input ctrl_cmd_t cmd,
	input in_item_t item,
	output dp_status_t st,
	input logic out_ready,
	output logic out_valid,
	output out_item_t out_data
);
	localparam int unsigned F = PHASE_FRACTION_BITS;
	localparam int unsigned AW = $clog2(SAMPLE_MEMORY_DEPTH);
	localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int unsigned PW = 17 + F;
	localparam int unsigned QW = F + 8;
	localparam int unsigned QCW = $clog2(QW);
	localparam int unsigned ACC_W = 16 + VW;
	localparam longint unsigned STEP_NUM = (PAULA_CLOCK << F) / RATE_DIVISOR;
	localparam logic [QW-1:0] STEP_NUM_V = QW'(STEP_NUM);
	localparam logic [PW:0] POS_HALF = (PW+1)'(1) << (F - 1);

	logic [11:0] per_q [VOICES];
	logic [11:0] tgt_q [VOICES];
	logic [7:0] spd_q [VOICES];
	logic [6:0] vol_q [VOICES];
	logic [PW-1:0] pos_q [VOICES];
	logic loop_q [VOICES];
	logic [16:0] start_q [VOICES];
	logic [16:0] len_q [VOICES];
	logic [16:0] ls_q [VOICES];
	logic [16:0] ll_q [VOICES];
	logic has_q [VOICES];
	logic [3:0] eff_q [VOICES];
	logic [7:0] arg_q [VOICES];

	logic [11:0] tick_per [VOICES];
	logic [6:0] tick_vol [VOICES];

	logic [VW-1:0] vidx_q;
	logic live_q;
	logic [11:0] div_per_q;
	logic [11:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [QCW-1:0] cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [3:0] act_q;
	logic out_valid_q;
	out_item_t out_q;

	logic [7:0] ram_rdata;
	logic [AW-1:0] ram_raddr;
	logic row_hit;
	logic [VW-1:0] row_ch;

	logic [PW-1:0] cur_pos;
	logic [PW:0] rsum;
	logic past_end;
	logic one_shot_end;
	logic live;
	logic [PW-1:0] pos1;
	logic [PW-1:0] pos2;
	logic loop1;
	logic [17:0] loop_end;
	logic [17:0] asum;

	logic [12:0] div_t;
	logic div_bit;
	logic [11:0] div_rem;

	logic signed [15:0] prod;
	logic signed [20:0] p_ext;
	logic signed [20:0] p127;
	logic signed [20:0] p_adj;
	logic signed [14:0] term;
	logic [PW:0] pos_sum;
	logic [PW-1:0] pos_new;

	logic signed [ACC_W-1:0] acc_adj;
	logic signed [ACC_W-1:0] mix_q4;
	logic signed [14:0] mix_sat;

	function automatic logic [11:0] porta(input logic [11:0] p, input logic [11:0] t,
			input logic [7:0] s);
		logic [11:0] r;
		r = p;
		if (p != 12'd0 && t != 12'd0) begin
			if (p > t) begin
				r = (p - t > {4'd0, s}) ? p - {4'd0, s} : t;
			end else if (p < t) begin
				r = (t - p > {4'd0, s}) ? p + {4'd0, s} : t;
			end
		end
		return r;
	endfunction

	function automatic logic [6:0] vslide(input logic [6:0] v, input logic [7:0] a);
		logic [3:0] up;
		logic [3:0] dn;
		logic [6:0] r;
		up = a[7:4];
		dn = a[3:0];
		r = v;
		if (!(up != 4'd0 && dn != 4'd0)) begin
			if (up != 4'd0) r = ({1'b0, v} + {4'd0, up} > {1'b0, VOLUME_MAX}) ?
				VOLUME_MAX : v + {3'd0, up};
			if (dn != 4'd0) r = (v > {3'd0, dn}) ? v - {3'd0, dn} : 7'd0;
		end
		return r;
	endfunction

	ftvm_ram #(
		.WIDTH(8),
		.DEPTH(SAMPLE_MEMORY_DEPTH)
	) u_mem (
		.clk(clk),
		.we(cmd.accept && item.opcode == OP_LOAD),
		.waddr(AW'(item.address)),
		.wdata(item.data_byte),
		.re(cmd.voice_eval),
		.raddr(ram_raddr),
		.rdata_q(ram_rdata)
	);

	// per-voice effect tick
	always_comb begin
		for (int v = 0; v < VOICES; v++) begin
			tick_per[v] = per_q[v];
			tick_vol[v] = vol_q[v];
			case (eff_q[v])
				EFF_SLIDE_UP: begin
					if (per_q[v] != 12'd0) begin
						tick_per[v] = ({1'b0, per_q[v]} < {1'b0, PERIOD_MIN} + {5'd0, arg_q[v]}) ?
							PERIOD_MIN : per_q[v] - {4'd0, arg_q[v]};
					end
				end
				EFF_SLIDE_DOWN: begin
					if (per_q[v] != 12'd0) begin
						tick_per[v] = ({1'b0, per_q[v]} + {5'd0, arg_q[v]} > {1'b0, PERIOD_MAX}) ?
							PERIOD_MAX : per_q[v] + {4'd0, arg_q[v]};
					end
				end
				EFF_TONE_PORTA: begin
					tick_per[v] = porta(per_q[v], tgt_q[v], spd_q[v]);
				end
				EFF_PORTA_VOL: begin
					tick_per[v] = porta(per_q[v], tgt_q[v], spd_q[v]);
					tick_vol[v] = vslide(vol_q[v], arg_q[v]);
				end
				EFF_VOL_SLIDE: begin
					tick_vol[v] = vslide(vol_q[v], arg_q[v]);
				end
				default: begin
				end
			endcase
		end
	end

	// voice evaluation and sample fetch
	always_comb begin
		row_ch = VW'(item.channel);
		row_hit = cmd.accept && item.opcode == OP_ROW && 32'(item.channel) < VOICES;
		cur_pos = pos_q[vidx_q];
		rsum = {1'b0, cur_pos} + POS_HALF;
		past_end = rsum[PW:F] >= {1'b0, len_q[vidx_q]};
		one_shot_end = past_end && ll_q[vidx_q] < 17'd2;
		live = has_q[vidx_q] && per_q[vidx_q] != 12'd0 && !one_shot_end;
		pos1 = past_end ? {ls_q[vidx_q], F'(0)} : cur_pos;
		loop1 = past_end || loop_q[vidx_q];
		loop_end = {1'b0, ls_q[vidx_q]} + {1'b0, ll_q[vidx_q]};
		pos2 = (loop1 && {1'b0, pos1} >= {loop_end, F'(0)}) ? {ls_q[vidx_q], F'(0)} : pos1;
		asum = {1'b0, start_q[vidx_q]} + {1'b0, pos2[PW-1:F]};
		ram_raddr = AW'(asum);
	end

	// step divider and accumulate
	always_comb begin
		div_t = {rem_q, STEP_NUM_V[cnt_q]};
		div_bit = div_t >= {1'b0, div_per_q};
		div_rem = div_bit ? 12'(div_t - {1'b0, div_per_q}) : div_t[11:0];

		prod = $signed(ram_rdata) * $signed({1'b0, vol_q[vidx_q]});
		p_ext = 21'(prod);
		p127 = (p_ext <<< 7) - p_ext;
		p_adj = (p127 < 0) ? p127 + 21'sd63 : p127;
		term = 15'(p_adj >>> 6);
		pos_sum = {1'b0, pos_q[vidx_q]} + (PW+1)'(quo_q);
		pos_new = pos_sum[PW] ? {PW{1'b1}} : pos_sum[PW-1:0];

		acc_adj = (acc_q < 0) ? acc_q + ACC_W'(3) : acc_q;
		mix_q4 = acc_adj >>> 2;
		if (mix_q4 > ACC_W'(16383)) mix_sat = 15'sd16383;
		else if (mix_q4 < -ACC_W'(16384)) mix_sat = -15'sd16384;
		else mix_sat = 15'(mix_q4);
	end

	always_comb begin
		st.voice_live = live;
		st.div_done = (cnt_q == QCW'(0));
		st.last_voice = (vidx_q == VW'(VOICES - 1));
		st.out_free = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				per_q[v] <= '0;
				tgt_q[v] <= '0;
				spd_q[v] <= '0;
				vol_q[v] <= VOLUME_MAX;
				pos_q[v] <= '0;
				loop_q[v] <= 1'b0;
				start_q[v] <= '0;
				len_q[v] <= '0;
				ls_q[v] <= '0;
				ll_q[v] <= '0;
				has_q[v] <= 1'b0;
				eff_q[v] <= '0;
				arg_q[v] <= '0;
			end
		end else if (row_hit) begin
			if (item.effect == EFF_TONE_PORTA) begin
				if (item.argument != 8'd0) spd_q[row_ch] <= item.argument;
				if (item.period != 12'd0) tgt_q[row_ch] <= item.period;
			end
			if (item.new_instrument) begin
				vol_q[row_ch] <= (item.instrument_volume > VOLUME_MAX) ?
					VOLUME_MAX : item.instrument_volume;
				start_q[row_ch] <= item.address;
				len_q[row_ch] <= item.sample_length;
				ls_q[row_ch] <= item.loop_start;
				ll_q[row_ch] <= item.loop_length;
				has_q[row_ch] <= 1'b1;
			end
			if (item.period != 12'd0) begin
				pos_q[row_ch] <= '0;
				if (item.effect != EFF_TONE_PORTA) per_q[row_ch] <= item.period;
				loop_q[row_ch] <= 1'b0;
			end
			if (item.effect == EFF_SET_VOL) begin
				vol_q[row_ch] <= (item.argument > {1'b0, VOLUME_MAX}) ?
					VOLUME_MAX : item.argument[6:0];
			end
			if (item.effect == EFF_OFFSET) begin
				pos_q[row_ch] <= {PW'(item.argument) << (8 + F)};
			end
			eff_q[row_ch] <= item.effect;
			arg_q[row_ch] <= item.argument;
		end else if (cmd.accept && item.opcode == OP_TICK) begin
			for (int v = 0; v < VOICES; v++) begin
				per_q[v] <= tick_per[v];
				vol_q[v] <= tick_vol[v];
			end
		end else if (cmd.voice_eval) begin
			if (has_q[vidx_q] && per_q[vidx_q] != 12'd0 && one_shot_end) begin
				per_q[vidx_q] <= '0;
				pos_q[vidx_q] <= '0;
			end else if (live) begin
				pos_q[vidx_q] <= pos2;
				loop_q[vidx_q] <= loop1;
			end
		end else if (cmd.voice_done && live_q) begin
			pos_q[vidx_q] <= pos_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q <= '0;
			live_q <= 1'b0;
			cnt_q <= '0;
			acc_q <= '0;
			act_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.mix_start) begin
				vidx_q <= '0;
				acc_q <= '0;
				act_q <= '0;
			end
			if (cmd.voice_eval) begin
				live_q <= live;
				cnt_q <= QCW'(QW - 1);
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q - QCW'(1);
			end
			if (cmd.voice_done) begin
				vidx_q <= st.last_voice ? VW'(0) : vidx_q + VW'(1);
				if (live_q) begin
					acc_q <= acc_q + ACC_W'(term);
					if (32'(vidx_q) < 4) act_q[2'(vidx_q)] <= 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.voice_eval) begin
			div_per_q <= per_q[vidx_q];
			rem_q <= '0;
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= div_rem;
			quo_q <= {quo_q[QW-2:0], div_bit};
		end
		if (cmd.out_load) begin
			out_q.mixed_sample <= mix_sat;
			out_q.active_voices <= act_q;
		end
	end
endmodule

/* sv/four_channel_tracker_voice_mixer_top.sv */
// load, row and tick items are accepted only while idle and produce no result
// a mix item is built voice by voice (evaluate, divide step by step, accumulate), then loaded
// into the output register once a previous result still held there has been taken
// a silent voice skips the divider; the shared phase step divider yields one quotient bit per cycle
// one item is worked on at a time; the result waits in an output register
// arst_n clears control and voice state (volume to 64); sample memory is not cleared
`include "four_channel_tracker_voice_mixer_top_assert.svh"
module four_channel_tracker_voice_mixer_top
	import ftvm_pkg::*;
#(
	parameter int unsigned SAMPLE_MEMORY_DEPTH = SAMPLE_MEMORY_DEPTH_DEF,
	parameter int unsigned VOICES = VOICES_DEF,
	parameter int unsigned PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	ftvm_chan_if.sink items,
	ftvm_chan_if.source results
);
	ctrl_cmd_t cmd;
	dp_status_t st;
	in_item_t item;
	out_item_t res;

	assign item = items.data;
	assign results.data = res;

	ftvm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(items.valid),
		.opcode(item.opcode),
		.in_ready(items.ready),
		.st(st),
		.cmd(cmd)
	);

	ftvm_dp #(
		.SAMPLE_MEMORY_DEPTH(SAMPLE_MEMORY_DEPTH),
		.VOICES(VOICES),
		.PHASE_FRACTION_BITS(PHASE_FRACTION_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.item(item),
		.st(st),
		.out_ready(results.ready),
		.out_valid(results.valid),
		.out_data(res)
	);

	`FTVM_ASSERT_IMM(a_no_overwrite, clk, arst_n, cmd.out_load, !results.valid || results.ready)
	`FTVM_ASSERT_NEXT(a_busy_after_mix, clk, arst_n, cmd.mix_start, !items.ready)
	`FTVM_ASSERT_IMM(a_valid_from_load, clk, arst_n, $rose(results.valid), $past(cmd.out_load))
endmodule

/* verif/tb_four_channel_tracker_voice_mixer_top.sv */
`timescale 1ns / 100ps
module tb_four_channel_tracker_voice_mixer_top;
	import ftvm_pkg::*;

	localparam int DEPTH = 131072;
	localparam int FRAC = 16;
	localparam longint unsigned POS_LIMIT = (64'd1 << (17 + FRAC)) - 1;
	localparam longint unsigned POS_HALF = 64'd1 << (FRAC - 1);
	localparam int LOW_REGION = 256;
	localparam int HIGH_BASE = 131040;

	logic clk;
	logic arst_n;
	ftvm_chan_if #(.T(in_item_t)) items_if ();
	ftvm_chan_if #(.T(out_item_t)) results_if ();

	four_channel_tracker_voice_mixer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if.sink),
		.results(results_if.source)
	);

	// mixer state mirror
	logic signed [7:0] sample_mem [0:DEPTH-1];
	int live_per [4];
	int target_per [4];
	int porta_speed [4];
	int volume [4];
	longint unsigned position [4];
	bit looping [4];
	int inst_start [4];
	int inst_len [4];
	int inst_loop_start [4];
	int inst_loop_len [4];
	bit has_inst [4];
	bit wild_inst [4];
	int cell_effect [4];
	int cell_arg [4];

	out_item_t mix_queue [$];
	int error_count = 0;
	bit idle_enable = 1;

	initial clk = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#50_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic report(string what, int got, int want);
		error_count++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	function automatic void mirror_reset();
		for (int c = 0; c < 4; c++) begin
			live_per[c] = 0; target_per[c] = 0; porta_speed[c] = 0;
			volume[c] = 64; position[c] = 0; looping[c] = 0;
			inst_start[c] = 0; inst_len[c] = 0; inst_loop_start[c] = 0;
			inst_loop_len[c] = 0; has_inst[c] = 0; wild_inst[c] = 0;
			cell_effect[c] = 0; cell_arg[c] = 0;
		end
	endfunction

	function automatic void tone_porta(int c);
		int p, t, s;
		p = live_per[c]; t = target_per[c]; s = porta_speed[c];
		if (p == 0 || t == 0) return;
		if (p > t) p = (p - t > s) ? p - s : t;
		else if (p < t) p = (t - p > s) ? p + s : t;
		live_per[c] = p;
	endfunction

	function automatic void vol_slide(int c, int a);
		int up, down, v;
		up = (a >> 4) & 15; down = a & 15; v = volume[c];
		if (up > 0 && down > 0) return;
		if (up > 0) v = (v + up > 64) ? 64 : v + up;
		if (down > 0) v = (v > down) ? v - down : 0;
		volume[c] = v;
	endfunction

	function automatic bit safe_extent(int s, int len, int ls, int ll);
		int ext;
		ext = (len > ls + ll) ? len : ls + ll;
		if (s < LOW_REGION) return s + ext <= LOW_REGION;
		if (s >= HIGH_BASE) return s + ext <= DEPTH + LOW_REGION;
		return 0;
	endfunction

	function automatic void apply_row(in_item_t it);
		int c, a;
		bit keep;
		c = it.channel; a = it.argument; keep = 0;
		if (it.effect == EFF_TONE_PORTA) begin
			if (a > 0) porta_speed[c] = a;
			if (it.period != 0) target_per[c] = it.period;
			keep = 1;
		end
		if (it.new_instrument) begin
			volume[c] = (it.instrument_volume > 64) ? 64 : it.instrument_volume;
			inst_start[c] = it.address;
			inst_len[c] = it.sample_length;
			inst_loop_start[c] = it.loop_start;
			inst_loop_len[c] = it.loop_length;
			has_inst[c] = 1;
			wild_inst[c] = !safe_extent(it.address, it.sample_length, it.loop_start,
				it.loop_length);
		end
		if (it.period != 0) begin
			position[c] = 0;
			if (!keep) live_per[c] = it.period;
			looping[c] = 0;
		end
		if (it.effect == EFF_SET_VOL) volume[c] = (a > 64) ? 64 : a;
		if (it.effect == EFF_OFFSET) position[c] = longint'(a * 256) << FRAC;
		cell_effect[c] = it.effect;
		cell_arg[c] = a;
	endfunction

	function automatic void apply_tick();
		int a, p;
		for (int c = 0; c < 4; c++) begin
			a = cell_arg[c]; p = live_per[c];
			case (cell_effect[c])
				EFF_SLIDE_UP: begin
					if (p != 0) live_per[c] = (p < PERIOD_MIN + a) ? PERIOD_MIN : p - a;
				end
				EFF_SLIDE_DOWN: begin
					if (p != 0) live_per[c] = (p + a > PERIOD_MAX) ? PERIOD_MAX : p + a;
				end
				EFF_TONE_PORTA: tone_porta(c);
				EFF_PORTA_VOL: begin
					tone_porta(c);
					vol_slide(c, a);
				end
				EFF_VOL_SLIDE: vol_slide(c, a);
				default: ;
			endcase
		end
	endfunction

	function automatic out_item_t mix_predict();
		out_item_t r;
		longint unsigned pos, step;
		int sum, s, mix;
		sum = 0;
		r.active_voices = '0;
		for (int c = 0; c < 4; c++) begin
			if (!has_inst[c] || live_per[c] == 0) continue;
			pos = position[c];
			if (((pos + POS_HALF) >> FRAC) >= longint'(inst_len[c])) begin
				if (inst_loop_len[c] < 2) begin
					live_per[c] = 0;
					position[c] = 0;
					continue;
				end
				pos = longint'(inst_loop_start[c]) << FRAC;
				looping[c] = 1;
			end
			if (looping[c] &&
				pos >= (longint'(inst_loop_start[c] + inst_loop_len[c]) << FRAC))
				pos = longint'(inst_loop_start[c]) << FRAC;
			s = sample_mem[(inst_start[c] + int'(pos >> FRAC)) % DEPTH];
			step = (PAULA_CLOCK << FRAC) / (longint'(live_per[c]) * RATE_DIVISOR);
			pos += step;
			if (pos > POS_LIMIT) pos = POS_LIMIT;
			position[c] = pos;
			r.active_voices[c] = 1'b1;
			sum += (s * 127 * volume[c]) / 64;
		end
		mix = sum / 4;
		if (mix > 16383) mix = 16383;
		if (mix < -16384) mix = -16384;
		r.mixed_sample = mix[14:0];
		return r;
	endfunction

	// one transfer on the item channel, with optional gap after it
	task automatic send_item(in_item_t it);
		items_if.valid <= 1'b1;
		items_if.data <= it;
		do @(posedge clk); while (!items_if.ready);
		case (it.opcode)
			OP_LOAD: sample_mem[it.address] = it.data_byte;
			OP_ROW: apply_row(it);
			OP_TICK: apply_tick();
			default: mix_queue.push_back(mix_predict());
		endcase
		@(negedge clk);
		if (idle_enable && $urandom_range(0, 5) == 0) begin
			items_if.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	function automatic in_item_t blank_item(logic [1:0] op);
		in_item_t it;
		it = '0;
		it.opcode = op;
		return it;
	endfunction

	task automatic load_byte(int addr, int value);
		in_item_t it;
		it = blank_item(OP_LOAD);
		it.address = addr;
		it.data_byte = value;
		send_item(it);
	endtask

	function automatic in_item_t safe_instrument(int ch);
		in_item_t it;
		int ext;
		it = blank_item(OP_ROW);
		it.channel = ch;
		it.new_instrument = 1'b1;
		it.address = $urandom_range(0, 1) ? $urandom_range(0, 200) :
			$urandom_range(HIGH_BASE, DEPTH - 1);
		ext = (it.address < LOW_REGION) ? LOW_REGION - it.address :
			DEPTH + LOW_REGION - it.address;
		it.sample_length = $urandom_range(0, ext);
		it.loop_start = $urandom_range(0, ext);
		it.loop_length = $urandom_range(0, ext - it.loop_start);
		it.instrument_volume = $urandom_range(0, 127);
		return it;
	endfunction

	task automatic send_row(int ch, int per, int eff, int a);
		in_item_t it;
		it = blank_item(OP_ROW);
		it.channel = ch;
		it.period = per;
		it.effect = eff;
		it.argument = a;
		send_item(it);
	endtask

	task automatic send_mix();
		in_item_t it;
		for (int c = 0; c < 4; c++) begin
			if (wild_inst[c]) begin
				it = safe_instrument(c);
				send_item(it);
			end
		end
		send_item(blank_item(OP_MIX));
	endtask

	task automatic wait_drained();
		while (mix_queue.size() != 0) @(posedge clk);
	endtask

	// receiver side with random backpressure
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_enable && $urandom_range(0, 7) == 0) begin
				results_if.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
			end
			results_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && results_if.valid && results_if.ready) begin
			if (mix_queue.size() == 0) begin
				report("unexpected transfer", 0, 0);
			end else begin
				want = mix_queue.pop_front();
				if (results_if.data.mixed_sample !== want.mixed_sample)
					report("mixed_sample", results_if.data.mixed_sample, want.mixed_sample);
				if (results_if.data.active_voices !== want.active_voices)
					report("active_voices", results_if.data.active_voices,
						want.active_voices);
			end
		end
	end

	task automatic test_silence();
		send_mix();
		send_item(blank_item(OP_TICK));
		send_mix();
	endtask

	task automatic test_memory_fill();
		for (int a = 0; a < LOW_REGION; a++)
			load_byte(a, (a == 0) ? -128 : (a == 1) ? 127 : $urandom_range(0, 255));
		for (int a = HIGH_BASE; a < DEPTH; a++)
			load_byte(a, $urandom_range(0, 255));
	endtask

	task automatic test_directed_rows();
		in_item_t it;
		for (int c = 0; c < 4; c++) begin
			it = blank_item(OP_ROW);
			it.channel = c;
			it.new_instrument = 1'b1;
			it.address = (c == 3) ? DEPTH - 16 : c * 40;
			it.sample_length = 32;
			it.loop_start = (c == 1) ? 0 : 8;
			it.loop_length = (c == 1) ? 1 : 16;
			it.instrument_volume = 127;
			it.period = (c == 2) ? 113 : 428;
			send_item(it);
		end
		send_mix();
		send_row(0, 0, EFF_SET_VOL, 200);
		send_row(1, 0, EFF_OFFSET, 0);
		send_row(2, 0, EFF_SLIDE_UP, 255);
		send_row(3, 0, EFF_SLIDE_DOWN, 255);
		send_item(blank_item(OP_TICK));
		send_mix();
		send_row(0, 0, EFF_TONE_PORTA, 4);
		send_row(1, 300, EFF_TONE_PORTA, 0);
		send_row(2, 0, EFF_PORTA_VOL, 8'h0F);
		send_row(3, 0, EFF_VOL_SLIDE, 8'hF0);
		repeat (2) send_item(blank_item(OP_TICK));
		send_mix();
		send_row(2, 0, EFF_VOL_SLIDE, 8'h11);
		send_row(3, 0, EFF_PORTA_VOL, 8'h30);
		send_item(blank_item(OP_TICK));
		repeat (12) send_mix();
	endtask

	task automatic test_random(int count);
		in_item_t it;
		int pick;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) begin
				items_if.valid <= 1'b0;
				wait_drained();
				@(negedge clk);
			end
			if (n == count - 150) idle_enable = 0;
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				send_mix();
			end else if (pick < 55) begin
				send_item(blank_item(OP_TICK));
			end else if (pick < 65) begin
				load_byte($urandom_range(0, 1) ? $urandom_range(0, LOW_REGION - 1) :
					$urandom_range(0, DEPTH - 1), $urandom_range(0, 255));
			end else begin
				if ($urandom_range(0, 4) == 0) begin
					it = blank_item(OP_ROW);
					it.channel = $urandom_range(0, 3);
					it.new_instrument = 1'b1;
					it.address = $urandom_range(0, DEPTH - 1);
					it.sample_length = $urandom_range(0, 131070);
					it.loop_start = $urandom_range(0, 131070);
					it.loop_length = $urandom_range(0, 131070);
					it.instrument_volume = $urandom_range(0, 127);
				end else begin
					it = safe_instrument($urandom_range(0, 3));
					it.new_instrument = $urandom_range(0, 1);
				end
				case ($urandom_range(0, 2))
					0: it.period = 0;
					1: it.period = $urandom_range(PERIOD_MIN, PERIOD_MAX);
					default: it.period = $urandom_range(1, 4095);
				endcase
				it.effect = $urandom_range(0, 1) ? $urandom_range(0, 15) :
					$urandom_range(0, 1) ? EFF_PORTA_VOL : EFF_TONE_PORTA;
				it.argument = $urandom_range(0, 255);
				it.data_byte = $urandom_range(0, 255);
				send_item(it);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.data = '0;
		mirror_reset();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_silence();
		test_memory_fill();
		test_directed_rows();
		test_random(790);
		items_if.valid <= 1'b0;
		wait_drained();
		repeat (120) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
